FILE: sv/morse_light_sample_decoder_macros.svh
// Assertion macros shared by the queue and back-end decoder modules.
`ifndef MORSE_LIGHT_SAMPLE_DECODER_MACROS_SVH
`define MORSE_LIGHT_SAMPLE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define MLSD_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("mlsd assertion failed");
`define MLSD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("mlsd assertion failed");
`else
`define MLSD_ASSERT_IMPLY(label, pre, post)
`define MLSD_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: sv/mlsd_pkg.sv
// Types, constants and the letter table of the Morse light sample decoder.
`default_nettype none
package mlsd_pkg;

   localparam int TIME_W         = 32;
   localparam int INTENSITY_W    = 16;
   localparam int ON_THRESHOLD_W = 16;
   localparam int MIT_W          = 24;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 24;
   localparam int LETTER_W       = 5;

   localparam logic [ON_THRESHOLD_W-1:0] ON_THRESHOLD_RESET = 16'd256;
   localparam logic [MIT_W-1:0]          MIT_PERIOD_RESET   = 24'd200000;

   localparam logic [CSR_INDEX_W-1:0] CSR_ON_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIT_PERIOD   = 2'd1;

   localparam int MAX_BITS   = 16;
   localparam int COUNT_W    = $clog2(MAX_BITS + 1);
   localparam int CODE_W     = MAX_BITS - 3;
   localparam int OFF_LIMIT  = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam int LETTER_COUNT = 26;
   localparam int LCODE_W      = 10;
   localparam int LLEN_W       = 4;

   localparam logic [LCODE_W-1:0] LETTER_CODE [LETTER_COUNT] = '{
      10'h00B, 10'h0D5, 10'h1AD, 10'h035, 10'h001, 10'h0AD, 10'h06D, 10'h055,
      10'h005, 10'h2DB, 10'h06B, 10'h0B5, 10'h01B, 10'h00D, 10'h0DB, 10'h16D,
      10'h36B, 10'h02D, 10'h015, 10'h003, 10'h02B, 10'h0AB, 10'h05B, 10'h1AB,
      10'h35B, 10'h1B5
   };

   localparam logic [LLEN_W-1:0] LETTER_LEN [LETTER_COUNT] = '{
      4'd4, 4'd8, 4'd9, 4'd6, 4'd1, 4'd8, 4'd7, 4'd7, 4'd3, 4'd10, 4'd7, 4'd8, 4'd5,
      4'd4, 4'd8, 4'd9, 4'd10, 4'd6, 4'd5, 4'd2, 4'd6, 4'd8, 4'd7, 4'd9, 4'd10, 4'd9
   };

   typedef enum logic [1:0] {
      STATUS_LETTER,
      STATUS_NO_MATCH,
      STATUS_ENDED
   } status_type;

   typedef struct packed {
      logic pick0_valid;
      logic pick0_on;
      logic pick1_valid;
      logic pick1_on;
      logic last;
   } pick_word_type;

endpackage
`default_nettype wire

FILE: sv/mlsd_if.sv
// Handshake channels of the decoder: samples in, results out, register writes.
`default_nettype none
interface mlsd_req_if import mlsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [TIME_W-1:0]      sample_time;
   logic [INTENSITY_W-1:0] intensity;
   logic                   last_sample;
   modport source (output valid, sample_time, intensity, last_sample, input ready);
   modport sink (input valid, sample_time, intensity, last_sample, output ready);
endinterface

interface mlsd_rsp_if import mlsd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LETTER_W-1:0] letter_index;
   status_type          status;
   modport source (output valid, letter_index, status, input ready);
   modport sink (input valid, letter_index, status, output ready);
endinterface

interface mlsd_csr_if import mlsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/mlsd_front.sv
// Front end: configuration registers, on/off classification and pick selection.
`default_nettype none
module mlsd_front import mlsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   mlsd_req_if.sink      req_chan,
   mlsd_csr_if.sink      csr_chan,
   output logic          push_valid,
   output pick_word_type push_word,
   input  logic          push_ready
);

   typedef enum logic {
      F_EDGE,
      F_ACTIVE
   } front_phase_type;

   front_phase_type             phase_ff, phase_in;
   logic [ON_THRESHOLD_W-1:0]   threshold_ff, threshold_in;
   logic [MIT_W-1:0]            mit_ff, mit_in;
   logic [TIME_W-1:0]           prev_time_ff, prev_time_in;
   logic [TIME_W-1:0]           target_ff, target_in;
   logic                        prev_on_ff, prev_on_in;
   logic                        have_prev_ff, have_prev_in;
   logic                        prev_picked_ff, prev_picked_in;

   logic                        accept;
   logic                        on;
   logic                        due;
   logic                        take_cur;
   logic                        second;
   logic [TIME_W-1:0]           dcur;
   logic [TIME_W-1:0]           dprev;
   logic [TIME_W-1:0]           target_cur;
   logic [TIME_W-1:0]           target_prev;
   logic [TIME_W-1:0]           target_edge;

   function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [MIT_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + (TIME_W + 1)'(b);
      return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   endfunction

   assign req_chan.ready = push_ready;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && push_ready;

   always_comb begin
      on          = req_chan.intensity > threshold_ff;
      target_cur  = add_sat(req_chan.sample_time, mit_ff);
      target_prev = add_sat(prev_time_ff, mit_ff);
      target_edge = add_sat(req_chan.sample_time, {1'b0, mit_ff[MIT_W-1:1]});
      due         = (phase_ff == F_ACTIVE) && have_prev_ff &&
                    (req_chan.sample_time > target_ff);
      dcur        = req_chan.sample_time - target_ff;
      dprev       = (target_ff >= prev_time_ff) ? target_ff - prev_time_ff : '0;
      take_cur    = prev_picked_ff || (dcur < dprev);
      second      = due && !take_cur && (req_chan.sample_time > target_prev);

      push_word.pick0_valid = due;
      push_word.pick0_on    = take_cur ? on : prev_on_ff;
      push_word.pick1_valid = second;
      push_word.pick1_on    = on;
      push_word.last        = req_chan.last_sample;
      push_valid            = req_chan.valid && (due || req_chan.last_sample);
   end

   always_comb begin
      phase_in       = phase_ff;
      threshold_in   = threshold_ff;
      mit_in         = mit_ff;
      prev_time_in   = prev_time_ff;
      target_in      = target_ff;
      prev_on_in     = prev_on_ff;
      have_prev_in   = have_prev_ff;
      prev_picked_in = prev_picked_ff;

      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_ON_THRESHOLD) begin
            threshold_in = csr_chan.data[ON_THRESHOLD_W-1:0];
         end else if (csr_chan.index == CSR_MIT_PERIOD) begin
            mit_in = csr_chan.data[MIT_W-1:0];
         end
      end

      if (accept) begin
         if (phase_ff == F_EDGE) begin
            if (have_prev_ff && (on != prev_on_ff)) begin
               phase_in  = F_ACTIVE;
               target_in = target_edge;
            end
         end else if (due) begin
            target_in = (take_cur || second) ? target_cur : target_prev;
         end
         prev_time_in   = req_chan.sample_time;
         prev_on_in     = on;
         have_prev_in   = 1'b1;
         prev_picked_in = due && (take_cur || second);
         if (req_chan.last_sample) begin
            phase_in       = F_EDGE;
            prev_time_in   = '0;
            target_in      = '0;
            prev_on_in     = 1'b0;
            have_prev_in   = 1'b0;
            prev_picked_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= F_EDGE;
         threshold_ff   <= ON_THRESHOLD_RESET;
         mit_ff         <= MIT_PERIOD_RESET;
         prev_time_ff   <= '0;
         target_ff      <= '0;
         prev_on_ff     <= 1'b0;
         have_prev_ff   <= 1'b0;
         prev_picked_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         threshold_ff   <= threshold_in;
         mit_ff         <= mit_in;
         prev_time_ff   <= prev_time_in;
         target_ff      <= target_in;
         prev_on_ff     <= prev_on_in;
         have_prev_ff   <= have_prev_in;
         prev_picked_ff <= prev_picked_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/mlsd_queue.sv
// Short first-in first-out queue of pick words between front and back end.
`default_nettype none
`include "morse_light_sample_decoder_macros.svh"
module mlsd_queue import mlsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  pick_word_type push_word,
   output logic          push_ready,
   output logic          pop_valid,
   output pick_word_type pop_word,
   input  logic          pop_ready
);

   pick_word_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;
   logic                  push_fire;
   logic                  pop_fire;

   function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign push_ready = count_ff != QCOUNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_fire ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   `MLSD_ASSERT_IMPLY(a_count_bound, 1'b1, count_ff <= QCOUNT_W'(QUEUE_DEPTH))
   `MLSD_ASSERT_NEXT(a_count_grows, push_fire && !pop_fire, count_ff == $past(count_ff) + 1'b1)

endmodule
`default_nettype wire

FILE: sv/mlsd_back.sv
// Back end: sync hunt, bit recording, letter match and the result register.
`default_nettype none
`include "morse_light_sample_decoder_macros.svh"
module mlsd_back import mlsd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  pick_word_type pop_word,
   output logic          pop_ready,
   mlsd_rsp_if.source    rsp_chan
);

   typedef enum logic [1:0] {
      PH_SYNC,
      PH_REC,
      PH_DONE
   } back_phase_type;

   typedef struct packed {
      back_phase_type      phase;
      logic [1:0]          off_run;
      logic [MAX_BITS-1:0] bit_store;
      logic [COUNT_W-1:0]  bit_count;
      logic                overflowed;
   } track_type;

   typedef struct packed {
      track_type           track;
      logic                hit;
      logic [LETTER_W-1:0] letter;
      status_type          status;
   } step_type;

   localparam track_type TRACK_RESET = '{
      phase: PH_SYNC, off_run: '0, bit_store: '0, bit_count: '0, overflowed: 1'b0
   };

   track_type           track_ff, track_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;
   status_type          status_ff, status_in;

   step_type            step0;
   step_type            step1;
   track_type           mid_track;
   logic                mid_hit;
   logic                pop_fire;

   function automatic step_type take_pick(track_type s, logic on);
      step_type            r;
      logic [COUNT_W-1:0]  len;
      logic [CODE_W-1:0]   code;
      logic                found;
      r        = '{track: s, hit: 1'b0, letter: '0, status: STATUS_NO_MATCH};
      len      = '0;
      code     = '0;
      found    = 1'b0;
      unique case (s.phase)
         PH_SYNC: begin
            if (on) begin
               r.track.off_run = '0;
            end else if (s.off_run == 2'(OFF_LIMIT - 1)) begin
               r.track.phase   = PH_REC;
               r.track.off_run = '0;
            end else begin
               r.track.off_run = s.off_run + 1'b1;
            end
         end
         PH_REC: begin
            if (s.bit_count >= COUNT_W'(MAX_BITS)) begin
               r.track.overflowed = 1'b1;
            end else begin
               r.track.bit_count = s.bit_count + 1'b1;
            end
            r.track.bit_store = {s.bit_store[MAX_BITS-2:0], on};
            if (on) begin
               r.track.off_run = '0;
            end else if (s.off_run != 2'(OFF_LIMIT - 1)) begin
               r.track.off_run = s.off_run + 1'b1;
            end else begin
               r.track.phase = PH_DONE;
               r.hit         = 1'b1;
               if (!r.track.overflowed && (r.track.bit_count >= COUNT_W'(OFF_LIMIT))) begin
                  len  = r.track.bit_count - COUNT_W'(OFF_LIMIT);
                  code = r.track.bit_store[MAX_BITS-1:OFF_LIMIT];
                  for (int k = 0; k < LETTER_COUNT; k++) begin
                     if (!found && (len != '0) && (len == COUNT_W'(LETTER_LEN[k])) &&
                         (code == CODE_W'(LETTER_CODE[k]))) begin
                        found    = 1'b1;
                        r.letter = LETTER_W'(k);
                        r.status = STATUS_LETTER;
                     end
                  end
               end
            end
         end
         PH_DONE: begin
            r.hit = 1'b0;
         end
         default: begin
            r.hit = 1'b0;
         end
      endcase
      return r;
   endfunction

   assign pop_ready          = !rsp_valid_ff || rsp_chan.ready;
   assign pop_fire           = pop_valid && pop_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.letter_index = letter_ff;
   assign rsp_chan.status       = status_ff;

   always_comb begin
      step0     = take_pick(track_ff, pop_word.pick0_on);
      mid_track = pop_word.pick0_valid ? step0.track : track_ff;
      mid_hit   = pop_word.pick0_valid && step0.hit;
      step1     = take_pick(mid_track, pop_word.pick1_on);

      track_in     = track_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      letter_in    = letter_ff;
      status_in    = status_ff;

      if (pop_fire) begin
         if (mid_hit) begin
            track_in     = mid_track;
            rsp_valid_in = 1'b1;
            letter_in    = step0.letter;
            status_in    = step0.status;
         end else if (pop_word.pick1_valid) begin
            track_in     = step1.track;
            rsp_valid_in = step1.hit;
            letter_in    = step1.letter;
            status_in    = step1.status;
         end else begin
            track_in     = mid_track;
            rsp_valid_in = 1'b0;
         end
         if (pop_word.last) begin
            if (!rsp_valid_in && (track_in.phase != PH_DONE)) begin
               rsp_valid_in = 1'b1;
               letter_in    = '0;
               status_in    = STATUS_ENDED;
            end
            track_in = TRACK_RESET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff     <= TRACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         track_ff     <= track_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      letter_ff <= letter_in;
      status_ff <= status_in;
   end

   `MLSD_ASSERT_IMPLY(a_letter_range, rsp_valid_ff && (status_ff == STATUS_LETTER), letter_ff <= LETTER_W'(LETTER_COUNT - 1))
   `MLSD_ASSERT_IMPLY(a_letter_zero, rsp_valid_ff && (status_ff != STATUS_LETTER), letter_ff == '0)

endmodule
`default_nettype wire

FILE: sv/morse_light_sample_decoder.sv
// Top level of the Morse light sample decoder.
// A sample's pick word is stored in the queue and its result word in the result register before it shows on rsp_chan.
// Throughput: one sample word per cycle while the queue has room; the front end decides picks combinationally.
// A four-entry queue decouples the front end from the letter matcher and result register.
// Reset is synchronous and active high; it restores both registers and clears the capture.
`default_nettype none
module morse_light_sample_decoder import mlsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mlsd_req_if.sink   req_chan,
   mlsd_rsp_if.source rsp_chan,
   mlsd_csr_if.sink   csr_chan
);

   logic          push_valid;
   logic          push_ready;
   pick_word_type push_word;
   logic          pop_valid;
   logic          pop_ready;
   pick_word_type pop_word;

   mlsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready)
   );

   mlsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop_ready  (pop_ready)
   );

   mlsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_word  (pop_word),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
